// File: design/psz_pkg.sv
// Shared constants and controller/datapath interface types for the profile segment splitter.
`timescale 1ns / 1ps

package psz_pkg;

   localparam int PROFILE_DEPTH_DEFAULT = 16;
   localparam int COORD_BITS_DEFAULT    = 32;
   localparam int CSR_W                 = 5;
   localparam int INDEX_W               = 4;
   localparam logic [CSR_W-1:0] CSR_RESET = 5'd2;

   // Commands from controller to datapath
   typedef struct packed {
      logic take_req;
      logic cur_from_prev;
      logic cur_from_new;
      logic save_prev;
      logic clear_prev;
      logic idx_zero;
      logic idx_last;
      logic idx_inc;
      logic idx_dec;
      logic scan_cap;
      logic z_flat;
      logic md_region;
      logic md_cross;
      logic z_from_md;
      logic cross_take;
      logic emit;
      logic flush;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic have_prev;
      logic new_end;
      logic pend_valid;
      logic out_free;
      logic idx_is_zero;
      logic idx_is_last;
      logic region_stop;
      logic flat;
      logic up;
      logic cross_hit;
      logic md_done;
   } sts_type;

endpackage

// File: design/profile_segment_split_z_map.sv
// Top level of the profile segment splitter with height mapping.
`timescale 1ns / 1ps

// A profile load word does not hold the block: it is ready again the next
// cycle. A path word is worked on alone: for every word it sends out, the
// block scans the profile store entry by entry (read, capture, check) to
// find the height region, then runs the shared multiply-divide unit unless
// the region is flat; each break point also costs a crossing scan (read,
// check per entry) and one more multiply-divide pass. A path word thus
// costs least when its first point is only held and most when its segment
// crosses every profile entry, set by the bit-serial multiply-divide unit
// and the single read port of the profile store. A finished word waits in a
// pending register until the next word or the flush moves it to the output
// register, so a stalled result side holds only the next word that must be
// staged behind it.

module profile_segment_split_z_map #(
   parameter int PROFILE_DEPTH = psz_pkg::PROFILE_DEPTH_DEFAULT,
   parameter int COORD_BITS    = psz_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // request words
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [psz_pkg::INDEX_W-1:0]  req_profile_index,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic                         req_path_end,
   // response words
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic signed [COORD_BITS-1:0] rsp_out_z,
   output logic                         rsp_run_last,
   output logic                         rsp_path_done,
   // profile count register
   input  logic                         csr_write_en,
   input  logic [psz_pkg::CSR_W-1:0]    csr_write_data
);

   psz_pkg::cmd_type cmd;
   psz_pkg::sts_type sts;

   // Sequence the work; hold the request side while a path word is in flight
   psz_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Store, arithmetic and the response register
   psz_datapath #(
      .DEPTH (PROFILE_DEPTH),
      .W     (COORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_type          (req_type),
      .req_profile_index (req_profile_index),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_path_end      (req_path_end),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z),
      .rsp_run_last      (rsp_run_last),
      .rsp_path_done     (rsp_path_done)
   );

   // The final point of a path always closes its word's run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_path_done || rsp_run_last))
      else $error("path_done without run_last");

   // A path word occupies the block in the following cycle
   a_path_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type) |=> req_stall)
      else $error("path word did not occupy the block");

   // A profile load leaves the block ready in the following cycle
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_type) |=> !req_stall)
      else $error("profile load held the block");

endmodule

// File: design/psz_muldiv.sv
// Sequential multiply-then-divide unit: base + trunc(num*dx/den), saturated.
`timescale 1ns / 1ps

module psz_muldiv #(
   parameter int W = psz_pkg::COORD_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] base,
   input  logic signed [W:0]   num,
   input  logic signed [W:0]   dx,
   input  logic signed [W:0]   den,
   output logic                done,
   output logic signed [W-1:0] result
);

   localparam int PW   = 2 * W + 2;
   localparam int CNTW = $clog2(PW);

   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_MUL  = 2'd1;
   localparam logic [1:0] P_DIV  = 2'd2;
   localparam logic [1:0] P_FIN  = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic [PW-1:0]     mcand_ff, mcand_in;
   logic [W:0]        mplier_ff, mplier_in;
   logic [PW-1:0]     acc_ff, acc_in;
   logic [W:0]        rem_ff, rem_in;
   logic [W:0]        den_ff, den_in;
   logic              neg_ff, neg_in;
   logic signed [W-1:0] base_ff, base_in;
   logic signed [W-1:0] res_ff, res_in;
   logic              done_ff, done_in;

   logic [W+1:0]      r2;
   logic              ge;
   logic [W+1:0]      r2_sub;
   logic              big;
   logic signed [W+1:0] sum;
   logic signed [W+1:0] sat_max;
   logic signed [W+1:0] sat_min;

   function automatic logic [W:0] mag(input logic signed [W:0] v);
      mag = v[W] ? (~v + 1'b1) : v;
   endfunction

   assign sat_max = {3'b000, {(W-1){1'b1}}};
   assign sat_min = {3'b111, {(W-1){1'b0}}};

   always_comb begin
      r2     = {rem_ff, acc_ff[PW-1]};
      ge     = r2 >= {1'b0, den_ff};
      r2_sub = r2 - {1'b0, den_ff};
      big    = |acc_ff[PW-1:W];
      if (neg_ff) begin
         sum = {{2{base_ff[W-1]}}, base_ff} - {2'b00, acc_ff[W-1:0]};
      end else begin
         sum = {{2{base_ff[W-1]}}, base_ff} + {2'b00, acc_ff[W-1:0]};
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      base_in   = base_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      case (phase_ff)
         P_IDLE: begin
            if (start) begin
               mcand_in  = PW'(mag(num));
               mplier_in = mag(dx);
               den_in    = mag(den);
               neg_in    = (num[W] ^ dx[W]) ^ den[W];
               base_in   = base;
               acc_in    = '0;
               cnt_in    = '0;
               phase_in  = P_MUL;
            end
         end
         P_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[PW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[W:1]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(W)) begin
               cnt_in   = '0;
               rem_in   = '0;
               phase_in = P_DIV;
            end
         end
         P_DIV: begin
            rem_in = ge ? r2_sub[W:0] : r2[W:0];
            acc_in = {acc_ff[PW-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(PW - 1)) begin
               phase_in = P_FIN;
            end
         end
         P_FIN: begin
            if (big) begin
               res_in = neg_ff ? sat_min[W-1:0] : sat_max[W-1:0];
            end else if (sum > sat_max) begin
               res_in = sat_max[W-1:0];
            end else if (sum < sat_min) begin
               res_in = sat_min[W-1:0];
            end else begin
               res_in = sum[W-1:0];
            end
            done_in  = 1'b1;
            phase_in = P_IDLE;
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      neg_ff    <= neg_in;
      base_ff   <= base_in;
      res_ff    <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// File: design/psz_datapath.sv
// Datapath: profile store, path point registers, scan index, result staging.
`timescale 1ns / 1ps

module psz_datapath #(
   parameter int DEPTH = psz_pkg::PROFILE_DEPTH_DEFAULT,
   parameter int W     = psz_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  psz_pkg::cmd_type             cmd,
   output psz_pkg::sts_type             sts,
   input  logic                         req_type,
   input  logic [psz_pkg::INDEX_W-1:0]  req_profile_index,
   input  logic signed [W-1:0]          req_coord_x,
   input  logic signed [W-1:0]          req_coord_y,
   input  logic                         req_path_end,
   input  logic                         csr_write_en,
   input  logic [psz_pkg::CSR_W-1:0]    csr_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [W-1:0]          rsp_out_x,
   output logic signed [W-1:0]          rsp_out_y,
   output logic signed [W-1:0]          rsp_out_z,
   output logic                         rsp_run_last,
   output logic                         rsp_path_done
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CW    = ($clog2(DEPTH + 1) > psz_pkg::CSR_W) ?
                          $clog2(DEPTH + 1) : psz_pkg::CSR_W;

   logic [psz_pkg::CSR_W-1:0] csr_ff;
   logic [CW-1:0]             csr_ext, n_clamp;
   logic [IDX_W-1:0]          n_last;

   logic signed [W-1:0] mem_x [DEPTH];
   logic signed [W-1:0] mem_y [DEPTH];
   logic signed [W-1:0] rd_x_ff, rd_y_ff;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;

   logic signed [W-1:0] new_x_ff, new_y_ff;
   logic                new_end_ff;
   logic signed [W-1:0] prev_x_ff, prev_y_ff;
   logic                have_prev_ff;
   logic signed [W-1:0] cur_x_ff, cur_y_ff;
   logic                cur_done_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic signed [W-1:0] ea_x_ff, ea_y_ff, eb_x_ff, eb_y_ff;
   logic signed [W-1:0] cross_x_ff;
   logic signed [W-1:0] z_ff;

   logic signed [W-1:0] pend_x_ff, pend_y_ff, pend_z_ff;
   logic                pend_done_ff, pend_valid_ff;
   logic signed [W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic                out_last_ff, out_done_ff, out_valid_ff;
   logic                out_free;

   logic                md_start, md_done;
   logic signed [W-1:0] md_base, md_res;
   logic signed [W:0]   md_num, md_dx, md_den;

   function automatic logic signed [W:0] sub1(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
      sub1 = {a[W-1], a} - {b[W-1], b};
   endfunction

   // Count clamp to the usable range of the store
   always_comb begin
      csr_ext = CW'(csr_ff);
      if (csr_ext < CW'(2)) begin
         n_clamp = CW'(2);
      end else if (csr_ext > CW'(DEPTH)) begin
         n_clamp = CW'(DEPTH);
      end else begin
         n_clamp = csr_ext;
      end
      n_last = IDX_W'(n_clamp - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= psz_pkg::CSR_RESET;
      end else if (csr_write_en) begin
         csr_ff <= csr_write_data;
      end
   end

   assign wr_en   = cmd.take_req && !req_type && (32'(req_profile_index) < 32'(DEPTH));
   assign wr_addr = IDX_W'(req_profile_index);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= req_coord_x;
         mem_y[wr_addr] <= req_coord_y;
      end
      rd_x_ff <= mem_x[idx_ff];
      rd_y_ff <= mem_y[idx_ff];
   end

   // Multiply-divide operand selection
   always_comb begin
      md_start = cmd.md_region || cmd.md_cross;
      if (cmd.md_cross) begin
         md_base = cur_y_ff;
         md_num  = sub1(new_y_ff, cur_y_ff);
         md_dx   = sub1(rd_x_ff, cur_x_ff);
         md_den  = sub1(new_x_ff, cur_x_ff);
      end else begin
         md_base = ea_y_ff;
         md_num  = sub1(eb_y_ff, ea_y_ff);
         md_dx   = sub1(cur_x_ff, ea_x_ff);
         md_den  = sub1(eb_x_ff, ea_x_ff);
      end
   end

   psz_muldiv #(.W(W)) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .base   (md_base),
      .num    (md_num),
      .dx     (md_dx),
      .den    (md_den),
      .done   (md_done),
      .result (md_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
      end else if (cmd.save_prev) begin
         have_prev_ff <= 1'b1;
         prev_x_ff    <= new_x_ff;
         prev_y_ff    <= new_y_ff;
      end else if (cmd.clear_prev) begin
         have_prev_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         new_x_ff   <= req_coord_x;
         new_y_ff   <= req_coord_y;
         new_end_ff <= req_path_end;
      end
      if (cmd.cur_from_prev) begin
         cur_x_ff    <= prev_x_ff;
         cur_y_ff    <= prev_y_ff;
         cur_done_ff <= 1'b0;
      end else if (cmd.cur_from_new) begin
         cur_x_ff    <= new_x_ff;
         cur_y_ff    <= new_y_ff;
         cur_done_ff <= 1'b1;
      end else if (cmd.cross_take) begin
         cur_x_ff <= cross_x_ff;
         cur_y_ff <= md_res;
      end
      if (cmd.idx_zero) begin
         idx_ff <= '0;
      end else if (cmd.idx_last) begin
         idx_ff <= n_last;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - 1'b1;
      end
      if (cmd.scan_cap) begin
         ea_x_ff <= eb_x_ff;
         ea_y_ff <= eb_y_ff;
         eb_x_ff <= rd_x_ff;
         eb_y_ff <= rd_y_ff;
      end
      if (cmd.md_cross) begin
         cross_x_ff <= rd_x_ff;
      end
      if (cmd.z_flat) begin
         z_ff <= ea_y_ff;
      end else if (cmd.z_from_md) begin
         z_ff <= md_res;
      end
      if (cmd.emit) begin
         pend_x_ff    <= cur_x_ff;
         pend_y_ff    <= cur_y_ff;
         pend_z_ff    <= z_ff;
         pend_done_ff <= cur_done_ff;
      end
      if ((cmd.emit && pend_valid_ff) || cmd.flush) begin
         out_x_ff    <= pend_x_ff;
         out_y_ff    <= pend_y_ff;
         out_z_ff    <= pend_z_ff;
         out_done_ff <= pend_done_ff;
         out_last_ff <= cmd.flush;
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.emit) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if ((cmd.emit && pend_valid_ff) || cmd.flush) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.have_prev   = have_prev_ff;
      sts.new_end     = new_end_ff;
      sts.pend_valid  = pend_valid_ff;
      sts.out_free    = out_free;
      sts.idx_is_zero = (idx_ff == '0);
      sts.idx_is_last = (idx_ff == n_last);
      sts.region_stop = ((ea_x_ff <= cur_x_ff) && (cur_x_ff < eb_x_ff)) || (idx_ff == n_last);
      sts.flat        = (ea_y_ff == eb_y_ff) || (ea_x_ff == eb_x_ff);
      sts.up          = cur_x_ff < new_x_ff;
      sts.cross_hit   = (cur_x_ff < new_x_ff) ?
                        ((cur_x_ff < rd_x_ff) && (rd_x_ff < new_x_ff)) :
                        ((new_x_ff < rd_x_ff) && (rd_x_ff < cur_x_ff));
      sts.md_done     = md_done;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_z     = out_z_ff;
   assign rsp_run_last  = out_last_ff;
   assign rsp_path_done = out_done_ff;

endmodule

// File: design/psz_ctrl.sv
// Controller: sequences region scans, crossing searches and result staging.
`timescale 1ns / 1ps

module psz_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_type,
   output logic             req_stall,
   output psz_pkg::cmd_type cmd,
   input  psz_pkg::sts_type sts
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PATH   = 4'd1;
   localparam logic [3:0] S_HSTART = 4'd2;
   localparam logic [3:0] S_HRD    = 4'd3;
   localparam logic [3:0] S_HCAP   = 4'd4;
   localparam logic [3:0] S_HCHK   = 4'd5;
   localparam logic [3:0] S_HCALC  = 4'd6;
   localparam logic [3:0] S_HWAIT  = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;
   localparam logic [3:0] S_CSTART = 4'd9;
   localparam logic [3:0] S_CRD    = 4'd10;
   localparam logic [3:0] S_CCHK   = 4'd11;
   localparam logic [3:0] S_CWAIT  = 4'd12;
   localparam logic [3:0] S_FIN    = 4'd13;
   localparam logic [3:0] S_FLUSH  = 4'd14;

   localparam logic RET_SEG = 1'b0;
   localparam logic RET_END = 1'b1;

   logic [3:0] state_ff, state_in;
   logic       ret_ff, ret_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               if (req_type) begin
                  state_in = S_PATH;
               end
            end
         end
         S_PATH: begin
            if (sts.have_prev) begin
               cmd.cur_from_prev = 1'b1;
               ret_in            = RET_SEG;
               state_in          = S_HSTART;
            end else begin
               state_in = S_FIN;
            end
         end
         S_HSTART: begin
            cmd.idx_zero = 1'b1;
            state_in     = S_HRD;
         end
         S_HRD: begin
            state_in = S_HCAP;
         end
         S_HCAP: begin
            cmd.scan_cap = 1'b1;
            state_in     = S_HCHK;
         end
         S_HCHK: begin
            if (!sts.idx_is_zero && sts.region_stop) begin
               state_in = S_HCALC;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_HRD;
            end
         end
         S_HCALC: begin
            if (sts.flat) begin
               cmd.z_flat = 1'b1;
               state_in   = S_EMIT;
            end else begin
               cmd.md_region = 1'b1;
               state_in      = S_HWAIT;
            end
         end
         S_HWAIT: begin
            if (sts.md_done) begin
               cmd.z_from_md = 1'b1;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!sts.pend_valid || sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = (ret_ff == RET_SEG) ? S_CSTART : S_FLUSH;
            end
         end
         S_CSTART: begin
            if (sts.up) begin
               cmd.idx_zero = 1'b1;
            end else begin
               cmd.idx_last = 1'b1;
            end
            state_in = S_CRD;
         end
         S_CRD: begin
            state_in = S_CCHK;
         end
         S_CCHK: begin
            if (sts.cross_hit) begin
               cmd.md_cross = 1'b1;
               state_in     = S_CWAIT;
            end else if (sts.up ? sts.idx_is_last : sts.idx_is_zero) begin
               state_in = S_FIN;
            end else begin
               cmd.idx_inc = sts.up;
               cmd.idx_dec = !sts.up;
               state_in    = S_CRD;
            end
         end
         S_CWAIT: begin
            if (sts.md_done) begin
               cmd.cross_take = 1'b1;
               state_in       = S_HSTART;
            end
         end
         S_FIN: begin
            if (sts.new_end) begin
               cmd.cur_from_new = 1'b1;
               cmd.clear_prev   = 1'b1;
               ret_in           = RET_END;
               state_in         = S_HSTART;
            end else begin
               cmd.save_prev = 1'b1;
               state_in      = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!sts.pend_valid) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_SEG;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

// File: verif/psz_checker.sv
// Scoreboard for the profile segment splitter: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module psz_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_type,
   input  logic [3:0]         req_profile_index,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic               req_path_end,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_out_x,
   input  logic signed [31:0] rsp_out_y,
   input  logic signed [31:0] rsp_out_z,
   input  logic               rsp_run_last,
   input  logic               rsp_path_done,
   input  logic               csr_write_en,
   input  logic [4:0]         csr_write_data,
   output int                 fail_count,
   output int                 pending_points,
   output int                 points_seen
);

   localparam longint CMAX = 64'sd2147483647;
   localparam longint CMIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               last;
      logic               done;
   } point_type;

   longint prof_x [16];
   longint prof_y [16];
   longint held_x, held_y;
   bit     held_valid;
   logic [4:0] count_reg;
   point_type expected_points [$];

   assign pending_points = expected_points.size();

   function automatic int live_count();
      int n;
      n = count_reg;
      if (n < 2) n = 2;
      if (n > 16) n = 16;
      return n;
   endfunction

   // base + trunc(num*dx/den), saturated; 128-bit product avoids overflow
   function automatic longint lerp(longint base, longint num, longint dx, longint den);
      logic signed [127:0] prod, quo;
      longint r;
      prod = 128'(signed'(num)) * 128'(signed'(dx));
      quo  = prod / 128'(signed'(den));
      if (quo > 128'sd4611686018427387904 || quo < -128'sd4611686018427387904)
         return (quo < 0) ? CMIN : CMAX;
      r = base + longint'(quo);
      if (r > CMAX) return CMAX;
      if (r < CMIN) return CMIN;
      return r;
   endfunction

   function automatic longint height_of(longint px);
      int n, k;
      n = live_count();
      k = n - 2;
      for (int i = 0; i + 1 < n; i++)
         if (prof_x[i] <= px && px < prof_x[i+1]) begin
            k = i;
            break;
         end
      if (prof_y[k] == prof_y[k+1] || prof_x[k] == prof_x[k+1]) return prof_y[k];
      return lerp(prof_y[k], prof_y[k+1] - prof_y[k], px - prof_x[k],
                  prof_x[k+1] - prof_x[k]);
   endfunction

   function automatic bit next_break(longint a, longint b, output longint bx);
      int n;
      n = live_count();
      bx = 0;
      if (a < b) begin
         for (int i = 0; i < n; i++)
            if (a < prof_x[i] && prof_x[i] < b) begin
               bx = prof_x[i];
               return 1;
            end
      end else begin
         for (int i = n - 1; i >= 0; i--)
            if (b < prof_x[i] && prof_x[i] < a) begin
               bx = prof_x[i];
               return 1;
            end
      end
      return 0;
   endfunction

   function automatic point_type make_point(longint x, longint y, bit done);
      point_type p;
      longint hz;
      hz = height_of(x);
      p.x = x[31:0];
      p.y = y[31:0];
      p.z = hz[31:0];
      p.last = 0;
      p.done = done;
      return p;
   endfunction

   task automatic split_segment(longint nx, longint ny, bit fin);
      point_type run [$];
      longint cx, cy, bx;
      if (held_valid) begin
         cx = held_x;
         cy = held_y;
         run.insert(run.size(), make_point(cx, cy, 0));
         while (run.size() < 17 && next_break(cx, nx, bx)) begin
            cy = lerp(cy, ny - cy, bx - cx, nx - cx);
            cx = bx;
            run.insert(run.size(), make_point(cx, cy, 0));
         end
      end
      if (fin) begin
         run.insert(run.size(), make_point(nx, ny, 1));
         held_valid = 0;
      end else begin
         held_x = nx;
         held_y = ny;
         held_valid = 1;
      end
      if (run.size() > 0) run[run.size()-1].last = 1;
      foreach (run[i]) expected_points.insert(expected_points.size(), run[i]);
   endtask

   always @(posedge clock) begin
      point_type exp_p, got;
      if (reset) begin
         held_valid = 0;
         held_x = 0;
         held_y = 0;
         count_reg = 5'd2;
         expected_points.delete();
         fail_count = 0;
         points_seen = 0;
         foreach (prof_x[i]) begin
            prof_x[i] = 0;
            prof_y[i] = 0;
         end
      end else begin
         if (csr_write_en) count_reg = csr_write_data;
         if (req_valid && !req_stall) begin
            if (req_type == 1'b0) begin
               prof_x[req_profile_index] = req_coord_x;
               prof_y[req_profile_index] = req_coord_y;
            end else
               split_segment(req_coord_x, req_coord_y, req_path_end);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_x, rsp_out_y, rsp_out_z, rsp_run_last, rsp_path_done};
            points_seen++;
            if (expected_points.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected word x=%0d y=%0d z=%0d", $realtime,
                           got.x, got.y, got.z);
            end else begin
               exp_p = expected_points.pop_front();
               if (got !== exp_p) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch exp x=%0d y=%0d z=%0d l=%0b d=%0b",
                               " got x=%0d y=%0d z=%0d l=%0b d=%0b"},
                              $realtime, exp_p.x, exp_p.y, exp_p.z, exp_p.last,
                              exp_p.done, got.x, got.y, got.z, got.last, got.done);
               end
            end
         end
      end
   end

endmodule

// File: verif/tb_profile_segment_split_z_map.sv
// Stimulus and verdict for the profile segment splitter testbench.
`timescale 1ns / 1ps

module tb_profile_segment_split_z_map;

   localparam int QUIET_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_type = 0;
   logic [3:0]  req_profile_index = 0;
   logic signed [31:0] req_coord_x = 0;
   logic signed [31:0] req_coord_y = 0;
   logic        req_path_end = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic        rsp_run_last, rsp_path_done;
   logic        csr_write_en = 0;
   logic [4:0]  csr_write_data = 0;

   int  fail_count, pending_points, points_seen;
   int  words_sent = 0;
   int  quiet_cycles = 0;
   bit  hold_off = 0;     // one-cycle request for a long receiver hold-off
   int  hold_left = 0;    // hold-off cycles still to run, counted by the receiver
   int  gap_left = 0;

   // profile currently loaded, so paths can be aimed across its breaks
   int  prof_lo = 0, prof_hi = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   profile_segment_split_z_map DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_profile_index(req_profile_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_path_end(req_path_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z), .rsp_run_last(rsp_run_last),
      .rsp_path_done(rsp_path_done),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   psz_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_profile_index(req_profile_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_path_end(req_path_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z), .rsp_run_last(rsp_run_last),
      .rsp_path_done(rsp_path_done),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_points(pending_points),
      .points_seen(points_seen)
   );

   // Receiver: own stall pattern, calm stretches, and a counted long hold-off on request.
   always @(posedge clock) begin
      int mode;
      if (reset) begin
         rsp_stall <= 0;
         hold_left <= 0;
      end else if (hold_off) begin
         rsp_stall <= 1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left <= hold_left - 1;
      end else begin
         mode = (words_sent / 40) % 3;
         if (mode == 0) rsp_stall <= 0;
         else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   // Watchdog: count cycles with no word moving on either side.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset ||
          hold_left > 0)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
         $display("** profile_segment_split_z_map: FAILED **");
         $finish;
      end
   end

   // Offer one word and hold it until accepted; insert bursty gaps between words.
   // Stall is registered, so its value between edges decides the next edge.
   task automatic send_word(bit kind, logic [3:0] idx, logic [31:0] x, logic [31:0] y,
                            bit fin);
      req_valid         <= 1;
      req_type          <= kind;
      req_profile_index <= idx;
      req_coord_x       <= x;
      req_coord_y       <= y;
      req_path_end      <= fin;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      words_sent++;
      if (gap_left == 0 && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 6);
      if (gap_left > 0) begin
         gap_left--;
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 0;
      @(posedge clock);
      while (pending_points != 0) @(posedge clock);
      repeat (600) @(posedge clock);   // a path word may still be at work after the last result
   endtask

   task automatic write_count(logic [4:0] n);
      req_valid      <= 0;
      csr_write_en   <= 1;
      csr_write_data <= n;
      @(posedge clock);
      csr_write_en   <= 0;
   endtask

   // Load all 16 entries sorted ascending, spaced over [lo, hi].
   task automatic load_profile(int lo, int hi, bit flat_runs);
      longint step, xv;
      logic [31:0] yv;
      step = (longint'(hi) - lo) / 16;
      for (int i = 0; i < 16; i++) begin
         xv = lo + step * i + ((step > 2) ? $urandom_range(0, 1) : 0);
         yv = (flat_runs && i % 3 == 1) ? 32'd500 : $urandom;
         send_word(0, i[3:0], xv[31:0], yv, 0);
      end
      prof_lo = lo;
      prof_hi = hi;
   endtask

   function automatic logic [31:0] path_x();
      int r;
      longint v;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom;
      if (r == 1) return ($urandom_range(0, 1) == 1) ? 32'h7fffffff : 32'h80000000;
      v = prof_lo + longint'($urandom_range(0, 1000)) * (longint'(prof_hi) - prof_lo) / 900
          - (longint'(prof_hi) - prof_lo) / 18;
      return v[31:0];
   endfunction

   initial begin
      logic [31:0] px, py;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: full-range profile, count extremes, extreme coordinates.
      load_profile(-2000000000, 2000000000, 1);
      write_count(16);
      send_word(1, 0, 32'h80000000, 32'h7fffffff, 0);
      send_word(1, 0, 32'h7fffffff, 32'h80000000, 0);           // crosses every entry
      send_word(1, 0, 32'h80000000, 32'h80000000, 0);           // and back down
      send_word(1, 0, 32'h80000000, 32'h00000000, 0);           // vertical segment
      send_word(1, 0, 32'h7fffffff, 32'h7fffffff, 1);
      send_word(1, 0, 32'h12345678, 32'hfedcba98, 1);           // lone end point
      send_word(0, 4'hf, 32'h7fffffff, 32'h80000000, 0);        // last entry past the range
      send_word(1, 0, 32'h0, 32'h1, 0);                          // held first point
      send_word(1, 0, 32'h7ffffff0, 32'hffffffff, 1);           // ends in the last region
      drain_results();
      write_count(0);                                            // clamps up to two
      send_word(1, 0, 32'h55555555, 32'haaaaaaaa, 0);
      send_word(1, 0, 32'haaaaaaaa, 32'h55555555, 1);
      drain_results();
      write_count(31);                                           // clamps down to sixteen
      send_word(0, 4'h3, 32'h0, 32'h0, 0);                       // zero-width region
      send_word(0, 4'h4, 32'h0, 32'h64, 0);
      send_word(1, 0, 32'hffffffff, 32'h1, 0);
      send_word(1, 0, 32'h1, 32'h0, 1);
      drain_results();

      // Random phases: new profile and count per phase, mostly well-formed paths.
      for (int ph = 0; ph < 8; ph++) begin
         int lo, hi;
         lo = (ph % 2) ? -$urandom_range(1000, 1000000) : -$urandom_range(1, 2000000000);
         hi = (ph % 2) ? $urandom_range(1000, 1000000) : $urandom_range(1, 2000000000);
         load_profile(lo, hi, ph[0]);
         write_count((ph == 3) ? 5'd2 : 5'($urandom_range(2, 16)));
         if (ph == 4) begin
            // receiver holds off on its own count while the sender keeps offering
            hold_off <= 1;
            @(posedge clock);
            hold_off <= 0;
         end
         for (int k = 0; k < 18; k++) begin
            px = path_x();
            py = ($urandom_range(0, 7) == 0) ?
                 (($urandom_range(0, 1) == 1) ? 32'h80000000 : 32'h7fffffff) : $urandom;
            send_word(1, 0, px, py, (k == 17) || ($urandom_range(0, 9) == 0));
         end
         drain_results();   // sender waits out every expected result
      end

      $display("Covered %0d request words and %0d result words over several profiles",
               words_sent, points_seen);
      $display("with profile counts from the clamped low end to sixteen, and long stalls.");
      if (fail_count == 0)
         $display("** profile_segment_split_z_map: PASSED **");
      else
         $display("** profile_segment_split_z_map: FAILED **");
      $finish;
   end

endmodule
